>>> src/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, masked while reset is high
`define QPR_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, masked while reset is high
`define QPR_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// next-cycle implication that also holds across reset
`define QPR_ASSERT_NEXT_ALL(lbl, clk, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

>>> src/qpr_pkg.sv
// types and constants of the quaternion point rotator
`default_nettype none

package qpr_pkg;

  localparam int COORD_W   = 24;
  localparam int QUAT_W    = 16;
  localparam int DIFF_W    = COORD_W + 1;
  localparam int PROD1_W   = DIFF_W + QUAT_W;
  localparam int T_W       = PROD1_W + 2;
  localparam int PROD2_W   = T_W + QUAT_W;
  localparam int PAIR_W    = PROD2_W + 1;
  localparam int R_W       = PAIR_W + 2;
  localparam int FRAC_DROP = 28;
  localparam int RND_W     = R_W - FRAC_DROP;
  localparam int SUM_W     = RND_W + 1;
  localparam int IDX_W     = 3;

  localparam logic signed [R_W-1:0] RND_BIAS = R_W'(1) <<< (FRAC_DROP - 1);
  localparam logic signed [COORD_W-1:0] COORD_MAX = 24'sh7FFFFF;
  localparam logic signed [COORD_W-1:0] COORD_MIN = -24'sh800000;
  localparam logic signed [QUAT_W-1:0] ROT_W_RESET = 16'sd16384;

  // configuration register indexes
  typedef enum logic [IDX_W-1:0] {
    REG_ROT_W    = 3'd0,
    REG_ROT_X    = 3'd1,
    REG_ROT_Y    = 3'd2,
    REG_ROT_Z    = 3'd3,
    REG_CENTER_X = 3'd4,
    REG_CENTER_Y = 3'd5,
    REG_CENTER_Z = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic signed [QUAT_W-1:0] w;
    logic signed [QUAT_W-1:0] x;
    logic signed [QUAT_W-1:0] y;
    logic signed [QUAT_W-1:0] z;
  } quat_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } coord_vec_t;

  typedef struct packed {
    logic signed [DIFF_W-1:0] x;
    logic signed [DIFF_W-1:0] y;
    logic signed [DIFF_W-1:0] z;
  } diff_vec_t;

  typedef struct packed {
    logic signed [T_W-1:0] w;
    logic signed [T_W-1:0] x;
    logic signed [T_W-1:0] y;
    logic signed [T_W-1:0] z;
  } tquat_t;

  typedef struct packed {
    logic signed [R_W-1:0] x;
    logic signed [R_W-1:0] y;
    logic signed [R_W-1:0] z;
  } rvec_t;

  // pipeline control handed to each section: global advance and beat valid
  typedef struct packed {
    logic en;
    logic vld;
  } pipe_ctl_t;

endpackage

`default_nettype wire

>>> src/qpr_sandwich_left.sv
// left product t = q * (0, d): products stage, then sum stage
`default_nettype none

module qpr_sandwich_left (
  input  logic                 clk,
  input  logic                 rst,
  input  qpr_pkg::pipe_ctl_t   ctl,
  input  qpr_pkg::quat_t       rot,
  input  qpr_pkg::diff_vec_t   d,
  output logic                 t_valid,
  output qpr_pkg::tquat_t      t
);

  logic                                  prod_valid;
  logic signed [qpr_pkg::PROD1_W-1:0]    wx, wy, wz;
  logic signed [qpr_pkg::PROD1_W-1:0]    xx, xy, xz;
  logic signed [qpr_pkg::PROD1_W-1:0]    yx, yy, yz;
  logic signed [qpr_pkg::PROD1_W-1:0]    zx, zy, zz;

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
      t_valid    <= 1'b0;
    end else if (ctl.en) begin
      prod_valid <= ctl.vld;
      t_valid    <= prod_valid;
    end
  end

  // twelve component products
  always_ff @(posedge clk) begin
    if (ctl.en) begin
      wx <= qpr_pkg::PROD1_W'(rot.w) * qpr_pkg::PROD1_W'(d.x);
      wy <= qpr_pkg::PROD1_W'(rot.w) * qpr_pkg::PROD1_W'(d.y);
      wz <= qpr_pkg::PROD1_W'(rot.w) * qpr_pkg::PROD1_W'(d.z);
      xx <= qpr_pkg::PROD1_W'(rot.x) * qpr_pkg::PROD1_W'(d.x);
      xy <= qpr_pkg::PROD1_W'(rot.x) * qpr_pkg::PROD1_W'(d.y);
      xz <= qpr_pkg::PROD1_W'(rot.x) * qpr_pkg::PROD1_W'(d.z);
      yx <= qpr_pkg::PROD1_W'(rot.y) * qpr_pkg::PROD1_W'(d.x);
      yy <= qpr_pkg::PROD1_W'(rot.y) * qpr_pkg::PROD1_W'(d.y);
      yz <= qpr_pkg::PROD1_W'(rot.y) * qpr_pkg::PROD1_W'(d.z);
      zx <= qpr_pkg::PROD1_W'(rot.z) * qpr_pkg::PROD1_W'(d.x);
      zy <= qpr_pkg::PROD1_W'(rot.z) * qpr_pkg::PROD1_W'(d.y);
      zz <= qpr_pkg::PROD1_W'(rot.z) * qpr_pkg::PROD1_W'(d.z);
    end
  end

  // hamilton product sums
  always_ff @(posedge clk) begin
    if (ctl.en) begin
      t.w <= -(qpr_pkg::T_W'(xx) + qpr_pkg::T_W'(yy) + qpr_pkg::T_W'(zz));
      t.x <= qpr_pkg::T_W'(wx) + qpr_pkg::T_W'(yz) - qpr_pkg::T_W'(zy);
      t.y <= qpr_pkg::T_W'(wy) + qpr_pkg::T_W'(zx) - qpr_pkg::T_W'(xz);
      t.z <= qpr_pkg::T_W'(wz) + qpr_pkg::T_W'(xy) - qpr_pkg::T_W'(yx);
    end
  end

endmodule

`default_nettype wire

>>> src/qpr_sandwich_right.sv
// right product r = t * conj(q), vector part: products, pair sums, final sum
`default_nettype none

module qpr_sandwich_right (
  input  logic                 clk,
  input  logic                 rst,
  input  qpr_pkg::pipe_ctl_t   ctl,
  input  qpr_pkg::quat_t       rot,
  input  qpr_pkg::tquat_t      t,
  output logic                 r_valid,
  output qpr_pkg::rvec_t       r
);

  logic                                  prod_valid;
  logic                                  pair_valid;
  logic signed [qpr_pkg::PROD2_W-1:0]    wxp, txw, tyz, tzy;
  logic signed [qpr_pkg::PROD2_W-1:0]    wyp, tyw, tzx, txz;
  logic signed [qpr_pkg::PROD2_W-1:0]    wzp, tzw, txy, tyx;
  logic signed [qpr_pkg::PAIR_W-1:0]     ax, bx, ay, by, az, bz;

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
      pair_valid <= 1'b0;
      r_valid    <= 1'b0;
    end else if (ctl.en) begin
      prod_valid <= ctl.vld;
      pair_valid <= prod_valid;
      r_valid    <= pair_valid;
    end
  end

  // twelve products of t with q
  always_ff @(posedge clk) begin
    if (ctl.en) begin
      wxp <= qpr_pkg::PROD2_W'(t.w) * qpr_pkg::PROD2_W'(rot.x);
      txw <= qpr_pkg::PROD2_W'(t.x) * qpr_pkg::PROD2_W'(rot.w);
      tyz <= qpr_pkg::PROD2_W'(t.y) * qpr_pkg::PROD2_W'(rot.z);
      tzy <= qpr_pkg::PROD2_W'(t.z) * qpr_pkg::PROD2_W'(rot.y);
      wyp <= qpr_pkg::PROD2_W'(t.w) * qpr_pkg::PROD2_W'(rot.y);
      tyw <= qpr_pkg::PROD2_W'(t.y) * qpr_pkg::PROD2_W'(rot.w);
      tzx <= qpr_pkg::PROD2_W'(t.z) * qpr_pkg::PROD2_W'(rot.x);
      txz <= qpr_pkg::PROD2_W'(t.x) * qpr_pkg::PROD2_W'(rot.z);
      wzp <= qpr_pkg::PROD2_W'(t.w) * qpr_pkg::PROD2_W'(rot.z);
      tzw <= qpr_pkg::PROD2_W'(t.z) * qpr_pkg::PROD2_W'(rot.w);
      txy <= qpr_pkg::PROD2_W'(t.x) * qpr_pkg::PROD2_W'(rot.y);
      tyx <= qpr_pkg::PROD2_W'(t.y) * qpr_pkg::PROD2_W'(rot.x);
    end
  end

  // pair sums
  always_ff @(posedge clk) begin
    if (ctl.en) begin
      ax <= qpr_pkg::PAIR_W'(txw) - qpr_pkg::PAIR_W'(wxp);
      bx <= qpr_pkg::PAIR_W'(tzy) - qpr_pkg::PAIR_W'(tyz);
      ay <= qpr_pkg::PAIR_W'(tyw) - qpr_pkg::PAIR_W'(wyp);
      by <= qpr_pkg::PAIR_W'(txz) - qpr_pkg::PAIR_W'(tzx);
      az <= qpr_pkg::PAIR_W'(tzw) - qpr_pkg::PAIR_W'(wzp);
      bz <= qpr_pkg::PAIR_W'(tyx) - qpr_pkg::PAIR_W'(txy);
    end
  end

  // final sum with half-lsb bias for rounding
  always_ff @(posedge clk) begin
    if (ctl.en) begin
      r.x <= qpr_pkg::R_W'(ax) + qpr_pkg::R_W'(bx) + qpr_pkg::RND_BIAS;
      r.y <= qpr_pkg::R_W'(ay) + qpr_pkg::R_W'(by) + qpr_pkg::RND_BIAS;
      r.z <= qpr_pkg::R_W'(az) + qpr_pkg::R_W'(bz) + qpr_pkg::RND_BIAS;
    end
  end

endmodule

`default_nettype wire

>>> src/qpr_finish.sv
// drop fraction bits, add the center back, saturate, output register
`default_nettype none

module qpr_finish (
  input  logic                 clk,
  input  logic                 rst,
  input  qpr_pkg::pipe_ctl_t   ctl,
  input  qpr_pkg::rvec_t       r,
  input  qpr_pkg::coord_vec_t  center,
  output logic                 out_valid,
  output qpr_pkg::coord_vec_t  res
);

  logic signed [qpr_pkg::SUM_W-1:0] sx, sy, sz;

  function automatic logic signed [qpr_pkg::COORD_W-1:0] sat(
    input logic signed [qpr_pkg::SUM_W-1:0] v
  );
    logic signed [qpr_pkg::COORD_W-1:0] o;
    if (v > qpr_pkg::SUM_W'(qpr_pkg::COORD_MAX)) begin
      o = qpr_pkg::COORD_MAX;
    end else if (v < qpr_pkg::SUM_W'(qpr_pkg::COORD_MIN)) begin
      o = qpr_pkg::COORD_MIN;
    end else begin
      o = v[qpr_pkg::COORD_W-1:0];
    end
    return o;
  endfunction

  // floor shift of the biased sum, then center
  always_comb begin
    sx = qpr_pkg::SUM_W'($signed(r.x[qpr_pkg::R_W-1:qpr_pkg::FRAC_DROP]))
       + qpr_pkg::SUM_W'(center.x);
    sy = qpr_pkg::SUM_W'($signed(r.y[qpr_pkg::R_W-1:qpr_pkg::FRAC_DROP]))
       + qpr_pkg::SUM_W'(center.y);
    sz = qpr_pkg::SUM_W'($signed(r.z[qpr_pkg::R_W-1:qpr_pkg::FRAC_DROP]))
       + qpr_pkg::SUM_W'(center.z);
  end

  // output beat
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.en) begin
      out_valid <= ctl.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      res.x <= sat(sx);
      res.y <= sat(sy);
      res.z <= sat(sz);
    end
  end

endmodule

`default_nettype wire

>>> src/quaternion_point_rotator.sv
// top level: config registers, center subtract stage and the rotation pipeline
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+-------------------------------
//   in       | in_valid / in_stall       | point_x, point_y, point_z
//   out      | out_valid / out_stall     | out_x, out_y, out_z
//   config   | cfg_wr_en                 | cfg_addr, cfg_data
//
// one point per cycle while in_stall is low; seven register stages
// (subtract, two for q*(0,d), three for the product with conj(q), finish).
// the whole pipeline advances together; it holds only while a result sits in
// the output register with out_stall high, and in_stall is high exactly then.
// rst clears the valid bits and loads the identity rotation about the origin.
`default_nettype none

module quaternion_point_rotator (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wr_en,
  input  logic [qpr_pkg::IDX_W-1:0]           cfg_addr,
  input  logic [qpr_pkg::COORD_W-1:0]         cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [qpr_pkg::COORD_W-1:0]  point_x,
  input  logic signed [qpr_pkg::COORD_W-1:0]  point_y,
  input  logic signed [qpr_pkg::COORD_W-1:0]  point_z,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [qpr_pkg::COORD_W-1:0]  out_x,
  output logic signed [qpr_pkg::COORD_W-1:0]  out_y,
  output logic signed [qpr_pkg::COORD_W-1:0]  out_z
);

  qpr_pkg::quat_t      rot;
  qpr_pkg::coord_vec_t center;
  qpr_pkg::diff_vec_t  d;
  qpr_pkg::tquat_t     t;
  qpr_pkg::rvec_t      r;
  qpr_pkg::coord_vec_t res;
  logic                en;
  logic                d_valid;
  logic                t_valid;
  logic                r_valid;

  // global advance
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      rot.w    <= qpr_pkg::ROT_W_RESET;
      rot.x    <= '0;
      rot.y    <= '0;
      rot.z    <= '0;
      center.x <= '0;
      center.y <= '0;
      center.z <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        qpr_pkg::REG_ROT_W:    rot.w    <= cfg_data[qpr_pkg::QUAT_W-1:0];
        qpr_pkg::REG_ROT_X:    rot.x    <= cfg_data[qpr_pkg::QUAT_W-1:0];
        qpr_pkg::REG_ROT_Y:    rot.y    <= cfg_data[qpr_pkg::QUAT_W-1:0];
        qpr_pkg::REG_ROT_Z:    rot.z    <= cfg_data[qpr_pkg::QUAT_W-1:0];
        qpr_pkg::REG_CENTER_X: center.x <= cfg_data;
        qpr_pkg::REG_CENTER_Y: center.y <= cfg_data;
        qpr_pkg::REG_CENTER_Z: center.z <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage 1: offset from the center
  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
    end else if (en) begin
      d_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d.x <= qpr_pkg::DIFF_W'(point_x) - qpr_pkg::DIFF_W'(center.x);
      d.y <= qpr_pkg::DIFF_W'(point_y) - qpr_pkg::DIFF_W'(center.y);
      d.z <= qpr_pkg::DIFF_W'(point_z) - qpr_pkg::DIFF_W'(center.z);
    end
  end

  qpr_sandwich_left u_left (
    .clk     (clk),
    .rst     (rst),
    .ctl     ('{en: en, vld: d_valid}),
    .rot     (rot),
    .d       (d),
    .t_valid (t_valid),
    .t       (t)
  );

  qpr_sandwich_right u_right (
    .clk     (clk),
    .rst     (rst),
    .ctl     ('{en: en, vld: t_valid}),
    .rot     (rot),
    .t       (t),
    .r_valid (r_valid),
    .r       (r)
  );

  qpr_finish u_finish (
    .clk       (clk),
    .rst       (rst),
    .ctl       ('{en: en, vld: r_valid}),
    .r         (r),
    .center    (center),
    .out_valid (out_valid),
    .res       (res)
  );

  assign out_x = res.x;
  assign out_y = res.y;
  assign out_z = res.z;

endmodule

`default_nettype wire

>>> src/qpr_checker.sv
// port-level checks of the rotator and their bind
`default_nettype none

`include "assert_macros.svh"

module qpr_checker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_stall,
  input  logic                                out_valid,
  input  logic                                out_stall,
  input  logic signed [qpr_pkg::COORD_W-1:0]  out_x,
  input  logic signed [qpr_pkg::COORD_W-1:0]  out_y,
  input  logic signed [qpr_pkg::COORD_W-1:0]  out_z
);

  // a held output beat keeps its valid and payload
  `QPR_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(out_x) && $stable(out_y) && $stable(out_z), "stalled output beat changed")

  // input is held back only by a stalled output beat
  `QPR_ASSERT_IMPL(a_stall_cause, clk, rst, in_stall, out_valid && out_stall, "input stalled without output backpressure")

  // a draining or empty output never holds the input back
  `QPR_ASSERT_IMPL(a_no_false_stall, clk, rst, !out_valid || !out_stall, !in_stall, "input stalled while output free")

  // reset empties the pipeline
  `QPR_ASSERT_NEXT_ALL(a_reset_empty, clk, rst, !out_valid, "output valid right after reset")

endmodule

bind quaternion_point_rotator qpr_checker u_qpr_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_x     (out_x),
  .out_y     (out_y),
  .out_z     (out_z)
);

`default_nettype wire
